// File: rtl/core/rob_pkg.sv
package rob_pkg;

	localparam int TAG_W  = 3;
	localparam int REG_W  = 5;
	localparam int DATA_W = 32;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_WRITE
	} rob_state_t;

	// per-beat decisions handed from the controller to the datapath
	typedef struct packed {
		logic advance;
		logic commit;
		logic alloc_ok;
		logic full;
		logic empty;
		logic val_we;
		logic val_sel_wb1;
		logic reg_we;
		logic fwd_wb0;
		logic fwd_wb1;
	} rob_step_t;

endpackage

// File: rtl/core/rob_ram.sv
module rob_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/rob_ctrl.sv
module rob_ctrl #(
	parameter int DEPTH = 8,
	localparam int PTR_W = $clog2(DEPTH),
	localparam int CNT_W = $clog2(DEPTH + 1)
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     out_free,
	input  logic                     alloc_valid,
	input  logic                     wb0_valid,
	input  logic [rob_pkg::TAG_W-1:0] wb0_tag,
	input  logic                     wb1_valid,
	input  logic [rob_pkg::TAG_W-1:0] wb1_tag,
	output logic [PTR_W-1:0]         head,
	output logic [PTR_W-1:0]         tail,
	output logic                     rd_en,
	output rob_pkg::rob_step_t       step
);

	import rob_pkg::*;

	rob_state_t state_q, state_d;
	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] count_q, count_d;
	logic [DEPTH-1:0] ready_q, ready_wb, ready_d;
	logic [PTR_W-1:0] wb0_idx, wb1_idx;
	logic             wb0_ok, wb1_ok;
	logic             commit, alloc_ok, advance;

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// tags at or above the depth are dropped
	assign wb0_ok  = wb0_valid && (int'(wb0_tag) < DEPTH);
	assign wb1_ok  = wb1_valid && (int'(wb1_tag) < DEPTH);
	assign wb0_idx = PTR_W'(wb0_tag);
	assign wb1_idx = PTR_W'(wb1_tag);

	always_comb begin
		ready_wb = ready_q;
		if (wb0_ok) begin
			ready_wb[wb0_idx] = 1'b1;
		end
		if (wb1_ok) begin
			ready_wb[wb1_idx] = 1'b1;
		end
	end

	// head entry is busy whenever the count is nonzero
	assign commit   = (count_q != '0) && ready_wb[head_q];
	assign alloc_ok = alloc_valid && ((count_q != CNT_W'(DEPTH)) || commit);
	assign count_d  = count_q - CNT_W'(commit) + CNT_W'(alloc_ok);

	always_comb begin
		ready_d = ready_wb;
		if (commit) begin
			ready_d[head_q] = 1'b0;
		end
		if (alloc_ok) begin
			ready_d[tail_q] = 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_WRITE;
			end
			ST_WRITE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_stall = 1'b1;
		rd_en    = 1'b0;
		advance  = 1'b0;
		step     = '0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
			end
			ST_READ: begin
				rd_en       = 1'b1;
				step.val_we = wb0_ok;
			end
			ST_WRITE: begin
				advance          = out_free;
				step.val_we      = out_free && wb1_ok;
				step.val_sel_wb1 = 1'b1;
				step.reg_we      = out_free && alloc_ok;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
		step.advance  = advance;
		step.commit   = commit;
		step.alloc_ok = alloc_ok;
		step.full     = (count_d == CNT_W'(DEPTH));
		step.empty    = (count_d == '0);
		step.fwd_wb0  = wb0_ok && (wb0_idx == head_q);
		step.fwd_wb1  = wb1_ok && (wb1_idx == head_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			ready_q <= '0;
		end else begin
			state_q <= state_d;
			if (advance) begin
				if (commit) begin
					head_q <= next_ptr(head_q);
				end
				if (alloc_ok) begin
					tail_q <= next_ptr(tail_q);
				end
				count_q <= count_d;
				ready_q <= ready_d;
			end
		end
	end

	assign head = head_q;
	assign tail = tail_q;

endmodule

// File: rtl/core/reorder_buffer_core.sv
// Reorder buffer with in-order retirement.
// Input channel (in_valid / in_stall): one beat is one pipeline step carrying
// an optional allocation request and two optional ALU writebacks.
// Output channel (out_valid / out_stall): exactly one beat per input beat with
// the allocation answer, the optional commit of the head entry and the
// full / empty status after the step.
// Within a step the writebacks apply first, then the head commits if ready,
// then the tail is allocated if there is room (a same-step commit frees one).
// Timing: a beat is accepted in the idle state; the read state reads the head
// entry from the value and register memories and writes writeback 0; the
// write state writes writeback 1 and the allocation, updates the pointers and
// loads the output register. No new beat is taken until the last leaves the
// write state, as the one-write-port value memory takes the writebacks in separate states.
// A finished result waits in the output register while out_stall is high; the
// next input beat may be accepted meanwhile, and its step holds in the write
// state until the output register is free.
// Reset clears the pointers, the count and the ready flags; the memories need
// no clearing since an entry is only read after it has been allocated.
module reorder_buffer_core #(
	parameter int DEPTH = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      alloc_valid,
	input  logic [rob_pkg::REG_W-1:0]  alloc_reg,
	input  logic                      wb0_valid,
	input  logic [rob_pkg::TAG_W-1:0]  wb0_tag,
	input  logic [rob_pkg::DATA_W-1:0] wb0_value,
	input  logic                      wb1_valid,
	input  logic [rob_pkg::TAG_W-1:0]  wb1_tag,
	input  logic [rob_pkg::DATA_W-1:0] wb1_value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      alloc_accepted,
	output logic [rob_pkg::TAG_W-1:0]  alloc_tag,
	output logic                      commit_valid,
	output logic [rob_pkg::REG_W-1:0]  commit_reg,
	output logic [rob_pkg::DATA_W-1:0] commit_value,
	output logic                      buffer_full,
	output logic                      buffer_empty
);

	import rob_pkg::*;

	localparam int PTR_W = $clog2(DEPTH);

	// latched input beat
	logic              alloc_valid_q;
	logic [REG_W-1:0]  alloc_reg_q;
	logic              wb0_valid_q, wb1_valid_q;
	logic [TAG_W-1:0]  wb0_tag_q, wb1_tag_q;
	logic [DATA_W-1:0] wb0_value_q, wb1_value_q;

	logic [PTR_W-1:0]  head, tail;
	logic              rd_en, out_free;
	rob_step_t         step;

	logic [DATA_W-1:0] val_rdata, val_wdata, head_value;
	logic [PTR_W-1:0]  val_waddr;
	logic [REG_W-1:0]  reg_rdata;

	// output register
	logic              out_valid_q;
	logic              alloc_accepted_q, commit_valid_q, buffer_full_q, buffer_empty_q;
	logic [TAG_W-1:0]  alloc_tag_q;
	logic [REG_W-1:0]  commit_reg_q;
	logic [DATA_W-1:0] commit_value_q;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			alloc_valid_q <= alloc_valid;
			alloc_reg_q   <= alloc_reg;
			wb0_valid_q   <= wb0_valid;
			wb0_tag_q     <= wb0_tag;
			wb0_value_q   <= wb0_value;
			wb1_valid_q   <= wb1_valid;
			wb1_tag_q     <= wb1_tag;
			wb1_value_q   <= wb1_value;
		end
	end

	rob_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.out_free   (out_free),
		.alloc_valid(alloc_valid_q),
		.wb0_valid  (wb0_valid_q),
		.wb0_tag    (wb0_tag_q),
		.wb1_valid  (wb1_valid_q),
		.wb1_tag    (wb1_tag_q),
		.head       (head),
		.tail       (tail),
		.rd_en      (rd_en),
		.step       (step)
	);

	// port 0 writes during the read cycle, port 1 in the update cycle
	assign val_waddr = step.val_sel_wb1 ? PTR_W'(wb1_tag_q) : PTR_W'(wb0_tag_q);
	assign val_wdata = step.val_sel_wb1 ? wb1_value_q : wb0_value_q;

	rob_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_val_ram (
		.clk  (clk),
		.we   (step.val_we),
		.waddr(val_waddr),
		.wdata(val_wdata),
		.re   (rd_en),
		.raddr(head),
		.rdata(val_rdata)
	);

	rob_ram #(
		.WIDTH(REG_W),
		.DEPTH(DEPTH)
	) u_reg_ram (
		.clk  (clk),
		.we   (step.reg_we),
		.waddr(tail),
		.wdata(alloc_reg_q),
		.re   (rd_en),
		.raddr(head),
		.rdata(reg_rdata)
	);

	// this beat's writebacks override the stored head value, port 1 first
	assign head_value = step.fwd_wb1 ? wb1_value_q :
	                    step.fwd_wb0 ? wb0_value_q : val_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step.advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step.advance) begin
			alloc_accepted_q <= step.alloc_ok;
			alloc_tag_q      <= step.alloc_ok ? TAG_W'(tail) : '0;
			commit_valid_q   <= step.commit;
			commit_reg_q     <= step.commit ? reg_rdata : '0;
			commit_value_q   <= step.commit ? head_value : '0;
			buffer_full_q    <= step.full;
			buffer_empty_q   <= step.empty;
		end
	end

	assign out_valid      = out_valid_q;
	assign alloc_accepted = alloc_accepted_q;
	assign alloc_tag      = alloc_tag_q;
	assign commit_valid   = commit_valid_q;
	assign commit_reg     = commit_reg_q;
	assign commit_value   = commit_value_q;
	assign buffer_full    = buffer_full_q;
	assign buffer_empty   = buffer_empty_q;

endmodule
